// File: rtl/core/fuel_cell_energy_estimator_core_macros.svh
// ----------------------------------------------------------------------------
// Fuel-cell energy estimator assertion macros
// Shared property wrappers for the checker of the estimator core.
// ----------------------------------------------------------------------------
`ifndef FUEL_CELL_ENERGY_ESTIMATOR_CORE_MACROS_SVH
`define FUEL_CELL_ENERGY_ESTIMATOR_CORE_MACROS_SVH

// Property checked only outside reset.
`define FCEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define FCEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/fcee_pkg.sv
// ----------------------------------------------------------------------------
// Fuel-cell energy estimator package
// Widths, constants, codes and the command and status types of the core.
// ----------------------------------------------------------------------------
package fcee_pkg;

  localparam int WINDOW_DEPTH = 10;
  localparam int WIN_AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W = 32 + FILL_W;
  localparam int DVD_W   = TOTAL_W;
  localparam int DVS_W   = 32;
  localparam int CNT_W   = $clog2(DVD_W + 1);

  localparam int IN_W  = 56;
  localparam int OUT_W = 112;

  // Result field positions inside out_tdata.
  localparam int OUT_PWR_LSB  = 0;
  localparam int OUT_MEAN_LSB = 32;
  localparam int OUT_PCT_LSB  = 64;
  localparam int OUT_NRG_LSB  = 79;
  localparam int OUT_TIME_LSB = 95;
  localparam int OUT_ANN_BIT  = 111;

  localparam logic [14:0] PCT_FULL    = 15'd25600;
  localparam logic [15:0] MIN_SCALE   = 16'd6000;
  localparam logic [31:0] MEAN_MIN_CW = 32'd100;

  // Full scale is 256 * 100. After a shift by eight, the division by 100 is a
  // multiply by the rounded-up value of 2^30 / 100 and a shift by 30.
  localparam logic [23:0] PCT_RECIP = 24'd10737419;

  localparam logic [15:0] MAX_ENERGY_RST = 16'd3000;
  localparam logic [9:0]  MIN_PRESS_RST  = 10'd20;
  localparam logic [9:0]  MAX_PRESS_RST  = 10'd350;

  // Status codes that keep the announcement quiet.
  localparam logic [7:0] STS_MUTE_OFF  = 8'd0;
  localparam logic [7:0] STS_MUTE_FIVE = 8'd5;
  localparam logic [7:0] STS_MUTE_SEVN = 8'd7;

  typedef enum logic [1:0] {
    CFG_MAX_ENERGY = 2'd0,
    CFG_MIN_PRESS  = 2'd1,
    CFG_MAX_PRESS  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_MEAN   = 2'd0,
    OP_PCT    = 2'd1,
    OP_ENERGY = 2'd2,
    OP_TIME   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PWR, ST_SUB, ST_ADD,
    ST_MEAN, ST_MEAN_W,
    ST_PMUL, ST_PDIV, ST_PDIV_W,
    ST_EMUL, ST_EDIV,
    ST_TMUL, ST_TDIV, ST_TDIV_W,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    op_t  mul_op;
    logic ram_re;
    logic acc_sub;
    logic acc_add;
    logic div_start;
    logic div_take;
    op_t  div_op;
    logic pct_fix;
    logic time_zero;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic pct_div;
    logic mean_low;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/fcee_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/fcee_ctrl.sv
// ----------------------------------------------------------------------------
// Estimator controller
// Sequences one report through the multiplier, window and divider.
// ----------------------------------------------------------------------------
module fcee_ctrl
  import fcee_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_op = OP_MEAN;
    cmd.div_op = OP_MEAN;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PWR;
        end
      end
      ST_PWR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_MEAN;
        cmd.ram_re = 1'b1;
        state_nxt  = ST_SUB;
      end
      ST_SUB: begin
        cmd.acc_sub = 1'b1;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_MEAN;
        state_nxt     = ST_MEAN_W;
      end
      ST_MEAN_W: begin
        cmd.div_op = OP_MEAN;
        if (!sts.div_busy) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_PCT;
        if (sts.pct_div) begin
          state_nxt = ST_PDIV;
        end else begin
          cmd.pct_fix = 1'b1;
          state_nxt   = ST_EMUL;
        end
      end
      ST_PDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_PCT;
        state_nxt     = ST_PDIV_W;
      end
      ST_PDIV_W: begin
        cmd.div_op = OP_PCT;
        if (!sts.div_busy) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_EMUL;
        end
      end
      ST_EMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_ENERGY;
        state_nxt  = ST_EDIV;
      end
      // The division by full scale is a reciprocal multiply that the
      // datapath finishes within this state.
      ST_EDIV: begin
        cmd.div_take = 1'b1;
        cmd.div_op   = OP_ENERGY;
        state_nxt    = ST_TMUL;
      end
      ST_TMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_TIME;
        if (sts.mean_low) begin
          cmd.time_zero = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_TIME;
        state_nxt     = ST_TDIV_W;
      end
      ST_TDIV_W: begin
        cmd.div_op = OP_TIME;
        if (!sts.div_busy) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/fcee_dp.sv
// ----------------------------------------------------------------------------
// Estimator datapath
// Configuration, shared multiplier, power window, shared divider and output.
// ----------------------------------------------------------------------------
module fcee_dp
  import fcee_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  // Configuration registers.
  logic [15:0] max_energy_r;
  logic [9:0]  min_press_r;
  logic [9:0]  max_press_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_energy_r <= MAX_ENERGY_RST;
      min_press_r  <= MIN_PRESS_RST;
      max_press_r  <= MAX_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_ENERGY: max_energy_r <= cfg_wdata;
        CFG_MIN_PRESS:  min_press_r  <= cfg_wdata[9:0];
        CFG_MAX_PRESS:  max_press_r  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Captured report.
  logic [7:0]  status_r;
  logic [15:0] volts_r;
  logic [15:0] amps_r;
  logic [15:0] press_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_r <= in_tdata[7:0];
      volts_r  <= in_tdata[23:8];
      amps_r   <= in_tdata[39:24];
      press_r  <= in_tdata[55:40];
    end
  end

  // Working results.
  logic [31:0] power_r;
  logic [31:0] mean_r;
  logic [14:0] pct_r;
  logic [15:0] energy_r;
  logic [15:0] minutes_r;

  // Pressure range decode.
  logic       above_lo;
  logic       below_hi;
  logic       range_ok;
  logic [9:0] press_ofs;
  logic [9:0] press_span;

  assign above_lo   = press_r > 16'(min_press_r);
  assign below_hi   = press_r < 16'(max_press_r);
  assign range_ok   = max_press_r > min_press_r;
  assign press_ofs  = press_r[9:0] - min_press_r;
  assign press_span = max_press_r - min_press_r;

  // Shared 16x16 multiplier with a registered product.
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] prod_r;

  always_comb begin
    case (cmd.mul_op)
      OP_MEAN: begin
        mul_a = volts_r;
        mul_b = amps_r;
      end
      OP_PCT: begin
        mul_a = 16'(press_ofs);
        mul_b = 16'(PCT_FULL);
      end
      OP_ENERGY: begin
        mul_a = max_energy_r;
        mul_b = 16'(pct_r);
      end
      OP_TIME: begin
        mul_a = energy_r;
        mul_b = MIN_SCALE;
      end
      default: begin
        mul_a = volts_r;
        mul_b = amps_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= 32'(mul_a) * 32'(mul_b);
    end
  end

  // Energy product over full scale. The product stays below 2^31, so after
  // the shift by eight the reciprocal multiply gives the exact quotient.
  logic [46:0] nrg_prod;
  logic [15:0] nrg_quot;

  assign nrg_prod = 47'(prod_r[30:8]) * 47'(PCT_RECIP);
  assign nrg_quot = nrg_prod[45:30];

  // Power window.
  logic [WIN_AW-1:0]  slot_r;
  logic [FILL_W-1:0]  fill_r;
  logic [TOTAL_W-1:0] total_r;
  logic [31:0]        old_power;
  logic               win_full;

  assign win_full = fill_r == FILL_W'(WINDOW_DEPTH);

  fcee_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_DEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (cmd.acc_add),
    .waddr (slot_r),
    .wdata (power_r),
    .re    (cmd.ram_re),
    .raddr (slot_r),
    .rdata (old_power)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      if (cmd.acc_sub && win_full) begin
        total_r <= total_r - TOTAL_W'(old_power);
      end
      if (cmd.acc_add) begin
        total_r <= total_r + TOTAL_W'(power_r);
        if (!win_full) begin
          fill_r <= fill_r + FILL_W'(1);
        end
        if (slot_r == WIN_AW'(WINDOW_DEPTH - 1)) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + WIN_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_sub) begin
      power_r <= prod_r;
    end
  end

  // Shared restoring divider, one quotient bit per cycle. The dividend
  // register shifts out toward the remainder and fills with quotient bits.
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_load;
  logic [DVS_W-1:0] dvs_load;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] rem_diff;
  logic             q_bit;

  always_comb begin
    case (cmd.div_op)
      OP_MEAN: begin
        dvd_load = total_r;
        dvs_load = DVS_W'(fill_r);
      end
      OP_PCT: begin
        dvd_load = DVD_W'(prod_r);
        dvs_load = DVS_W'(press_span);
      end
      OP_TIME: begin
        dvd_load = DVD_W'(prod_r);
        dvs_load = mean_r;
      end
      default: begin
        dvd_load = total_r;
        dvs_load = DVS_W'(fill_r);
      end
    endcase
  end

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign q_bit    = !rem_diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= dvd_load;
      dvs_r <= dvs_load;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (cmd.div_take) begin
      case (cmd.div_op)
        OP_MEAN:   mean_r   <= dvd_r[31:0];
        OP_PCT:    pct_r    <= dvd_r[14:0];
        OP_ENERGY: energy_r <= nrg_quot;
        OP_TIME:   minutes_r <= (|dvd_r[DVD_W-1:16]) ? 16'hFFFF : dvd_r[15:0];
        default: ;
      endcase
    end
    if (cmd.pct_fix) begin
      pct_r <= above_lo ? PCT_FULL : 15'd0;
    end
    if (cmd.time_zero) begin
      minutes_r <= '0;
    end
  end

  // Output register.
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             announce;

  assign announce = (status_r != STS_MUTE_OFF) && (status_r != STS_MUTE_FIVE) &&
                    (status_r != STS_MUTE_SEVN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {announce, minutes_r, energy_r, pct_r, mean_r, power_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.div_busy = cnt_r != '0;
  assign sts.pct_div  = above_lo && range_ok && below_hi;
  assign sts.mean_low = mean_r <= MEAN_MIN_CW;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

// File: rtl/core/fuel_cell_energy_estimator_core.sv
// ----------------------------------------------------------------------------
// Fuel-cell energy estimator core
// Power, window mean, tank percentage, remaining energy and time per report.
// ----------------------------------------------------------------------------
// One report is worked on at a time. Its time from transfer to result is
// set by the shared restoring divider, which produces one quotient bit per
// cycle for each of three divisions, and by any wait for the output
// register to free. The energy division by full scale is a shift and a
// reciprocal multiply rather than a pass through the divider. When the
// pressure lies at or outside the range bounds, the range is empty or
// inverted, or the mean power is 1 W or less, the matching division is
// skipped and the report finishes sooner. The core is ready for the next
// report as soon as the result sits in the output register, even while that
// result still waits for its transfer. After reset the window is empty and
// needs no clearing.
module fuel_cell_energy_estimator_core
  import fcee_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // status_code[7:0], load_voltage_tenths[23:8], output_current_tenths[39:24],
  // total_pressure_tenths[55:40]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // instant_power_cw[31:0], mean_power_cw[63:32], percent_remaining_q8[78:64],
  // remaining_energy_wh[94:79], remaining_time_min[110:95], announce_active[111]
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  fcee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcee_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/core/fcee_chk.sv
// ----------------------------------------------------------------------------
// Estimator port checker
// Watches the ports of the estimator core over time.
// ----------------------------------------------------------------------------
`include "fuel_cell_energy_estimator_core_macros.svh"

module fcee_chk
  import fcee_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result keeps its place and its value.
  `FCEE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `FCEE_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled result changed")

  // A report is worked on alone, so no transfer directly follows another.
  `FCEE_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "input taken while busy")

  // The percentage never passes full.
  `FCEE_ASSERT(a_pct_range, out_tvalid |-> out_tdata[OUT_NRG_LSB-1:OUT_PCT_LSB] <= PCT_FULL, "percentage above full")

  `FCEE_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result present after reset")

endmodule

bind fuel_cell_energy_estimator_core fcee_chk u_fcee_chk (.*);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Fuel-cell energy estimator core testbench
// Streams status reports through the core under several register settings
// and compares every estimate with a cycle-free prediction of the same math.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fcee_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  // Holds the mirrored window and registers and the estimates still due.
  class estimate_scoreboard;
    logic [31:0]      window_pwr [WINDOW_DEPTH];
    int unsigned      fill_cnt;
    int unsigned      wr_slot;
    logic [63:0]      pwr_total;
    logic [15:0]      full_energy;
    logic [9:0]       empty_press;
    logic [9:0]       full_press;
    logic [OUT_W-1:0] expected_estimates [$];
    int unsigned      mismatches;

    function new();
      fill_cnt    = 0;
      wr_slot     = 0;
      pwr_total   = '0;
      full_energy = MAX_ENERGY_RST;
      empty_press = MIN_PRESS_RST;
      full_press  = MAX_PRESS_RST;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] value);
      case (idx)
        CFG_MAX_ENERGY: full_energy = value;
        CFG_MIN_PRESS:  empty_press = value[9:0];
        CFG_MAX_PRESS:  full_press  = value[9:0];
        default: ;
      endcase
    endfunction

    function logic [14:0] tank_pct(logic [15:0] press);
      logic [63:0] num;
      if (press <= 16'(empty_press)) return '0;
      // An inverted or empty range degenerates to a step at the minimum.
      if (full_press <= empty_press || press >= 16'(full_press)) return PCT_FULL;
      num = (64'(press) - 64'(empty_press)) * 64'(PCT_FULL);
      return 15'(num / 64'(full_press - empty_press));
    endfunction

    function void predict_estimate(logic [IN_W-1:0] rpt);
      logic [7:0]  status;
      logic [15:0] volts;
      logic [15:0] amps;
      logic [15:0] press;
      logic [31:0] power;
      logic [31:0] mean;
      logic [14:0] pct;
      logic [15:0] energy;
      logic [15:0] minutes;
      logic [63:0] quot;
      logic        announce;
      status = rpt[7:0];
      volts  = rpt[23:8];
      amps   = rpt[39:24];
      press  = rpt[55:40];
      power  = 32'(volts) * 32'(amps);
      if (fill_cnt >= WINDOW_DEPTH) pwr_total = pwr_total - 64'(window_pwr[wr_slot]);
      else fill_cnt++;
      window_pwr[wr_slot] = power;
      pwr_total = pwr_total + 64'(power);
      wr_slot = (wr_slot + 1 >= WINDOW_DEPTH) ? 0 : wr_slot + 1;
      mean   = 32'(pwr_total / 64'(fill_cnt));
      pct    = tank_pct(press);
      energy = 16'((64'(full_energy) * 64'(pct)) / 64'(PCT_FULL));
      if (mean <= MEAN_MIN_CW) begin
        minutes = '0;
      end else begin
        quot    = (64'(energy) * 64'(MIN_SCALE)) / 64'(mean);
        minutes = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
      end
      announce = (status != STS_MUTE_OFF) && (status != STS_MUTE_FIVE) &&
                 (status != STS_MUTE_SEVN);
      expected_estimates.push_back({announce, minutes, energy, pct, mean, power});
    endfunction

    task report_error(string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(logic [OUT_W-1:0] res);
      logic [OUT_W-1:0] exp_res;
      if (expected_estimates.size() == 0) begin
        report_error("estimate with no report pending");
        return;
      end
      exp_res = expected_estimates.pop_front();
      compare_field("instant_power_cw", res[OUT_PWR_LSB +: 32], exp_res[OUT_PWR_LSB +: 32]);
      compare_field("mean_power_cw", res[OUT_MEAN_LSB +: 32], exp_res[OUT_MEAN_LSB +: 32]);
      compare_field("percent_remaining_q8", 32'(res[OUT_PCT_LSB +: 15]),
                    32'(exp_res[OUT_PCT_LSB +: 15]));
      compare_field("remaining_energy_wh", 32'(res[OUT_NRG_LSB +: 16]),
                    32'(exp_res[OUT_NRG_LSB +: 16]));
      compare_field("remaining_time_min", 32'(res[OUT_TIME_LSB +: 16]),
                    32'(exp_res[OUT_TIME_LSB +: 16]));
      compare_field("announce_active", 32'(res[OUT_ANN_BIT]), 32'(exp_res[OUT_ANN_BIT]));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  // status_code[7:0], load_voltage_tenths[23:8], output_current_tenths[39:24],
  // total_pressure_tenths[55:40]
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  // instant_power_cw[31:0], mean_power_cw[63:32], percent_remaining_q8[78:64],
  // remaining_energy_wh[94:79], remaining_time_min[110:95], announce_active[111]
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_wdata;

  estimate_scoreboard sb;
  int          burst_left = 1;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int unsigned rx_count = 0;
  int unsigned quiet_cycles = 0;

  fuel_cell_energy_estimator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.predict_estimate(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // The receiver switches among four stall behaviors at random and
  // takes one long hold-off whenever the stimulus asks for it.
  always @(posedge clk) begin
    rx_count++;
    if (rx_count % 500 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ((rx_count % 9) < 4);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_report(logic [7:0] st, logic [15:0] volts,
                                                  logic [15:0] amps, logic [15:0] press);
    return {press, amps, volts, st};
  endfunction

  function automatic logic [15:0] pick_level(int typical);
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom_range(0, 20));
      7, 8:    return 16'($urandom);
      9:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, typical));
    endcase
  endfunction

  // Quiet runs keep the window power low so the low-mean and saturated
  // remaining-time paths get exercised.
  function automatic logic [IN_W-1:0] random_report(bit quiet);
    logic [7:0]  st;
    logic [15:0] volts;
    logic [15:0] amps;
    logic [15:0] press;
    logic [15:0] lo;
    logic [15:0] hi;
    lo = 16'(sb.empty_press);
    hi = 16'(sb.full_press);
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 2))
        0:       st = STS_MUTE_OFF;
        1:       st = STS_MUTE_FIVE;
        default: st = STS_MUTE_SEVN;
      endcase
    end else begin
      st = 8'($urandom);
    end
    volts = quiet ? 16'($urandom_range(0, 12)) : pick_level(700);
    amps  = quiet ? 16'($urandom_range(0, 12)) : pick_level(3000);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: press = 16'($urandom_range(0, 1100));
      5, 6: begin
        case ($urandom_range(0, 5))
          0:       press = lo - 16'd1;
          1:       press = lo;
          2:       press = lo + 16'd1;
          3:       press = hi - 16'd1;
          4:       press = hi;
          default: press = hi + 16'd1;
        endcase
      end
      default: press = 16'($urandom);
    endcase
    return pack_report(st, volts, amps, press);
  endfunction

  task automatic send_report(logic [IN_W-1:0] rpt);
    in_tvalid <= 1'b1;
    in_tdata  <= rpt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = $urandom_range(1, 12);
    do @(posedge clk); while (sb.expected_estimates.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_phase_config(int ph);
    logic [9:0] lo;
    logic [9:0] hi;
    case (ph)
      1: begin
        put_reg(CFG_MAX_ENERGY, 16'hFFFF);
        put_reg(CFG_MIN_PRESS, 16'd0);
        put_reg(CFG_MAX_PRESS, 16'd1023);
      end
      2: begin
        put_reg(CFG_MAX_ENERGY, 16'd0);
        put_reg(CFG_MIN_PRESS, 16'd1023);
        put_reg(CFG_MAX_PRESS, 16'd0);
        put_reg(CFG_UNUSED, 16'($urandom));
      end
      3: begin
        put_reg(CFG_MAX_ENERGY, 16'($urandom));
        put_reg(CFG_MIN_PRESS, 16'd500);
        put_reg(CFG_MAX_PRESS, 16'd500);
      end
      default: begin
        lo = 10'($urandom_range(0, 700));
        hi = 10'($urandom_range(int'(lo) + 1, 1023));
        // Upper data bits are junk that the pressure registers must drop.
        put_reg(CFG_MAX_ENERGY, 16'($urandom));
        put_reg(CFG_MIN_PRESS, {6'($urandom), lo});
        put_reg(CFG_MAX_PRESS, {6'($urandom), hi});
        if (ph == 5) put_reg(CFG_UNUSED, 16'($urandom));
      end
    endcase
  endtask

  task automatic run_directed();
    // Low window power first: saturated time, then a mean at or below 1 W.
    send_report(pack_report(STS_MUTE_OFF, 16'd11, 16'd11, 16'hFFFF));
    send_report(pack_report(STS_MUTE_FIVE, 16'd10, 16'd10, 16'd400));
    send_report(pack_report(STS_MUTE_SEVN, 16'd0, 16'd0, 16'd0));
    send_report(pack_report(8'd1, 16'd1, 16'd1, 16'd20));
    send_report(pack_report(8'd255, 16'd3, 16'd7, 16'd21));
    send_report(pack_report(8'd4, 16'd2, 16'd50, 16'd349));
    send_report(pack_report(8'd6, 16'd10, 16'd10, 16'd350));
    send_report(pack_report(8'd8, 16'd100, 16'd100, 16'd351));
    send_report(pack_report(8'd255, 16'd10, 16'd10, 16'd185));
    // Full-scale samples wrap the window and drive the total to its top.
    for (int k = 0; k < 11; k++)
      send_report(pack_report(8'($urandom), 16'hFFFF, 16'hFFFF, 16'(k * 37)));
    send_report(pack_report(8'd2, 16'hFFFF, 16'd0, 16'd0));
    send_report(pack_report(8'd3, 16'd0, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic run_random(int count, bit pause_mid);
    bit quiet;
    quiet = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (pause_mid && n == count / 2) wait_drained();
      send_report(random_report(quiet));
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_drained();
    for (int ph = 1; ph <= 6; ph++) begin
      set_phase_config(ph);
      // The receiver backs off for a long while so the core fills and stalls.
      if (ph == 1) hold_token <= hold_token + 1;
      run_random(160, ph == 4);
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (sb.expected_estimates.size() != 0) sb.report_error("estimates still pending at end");
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
